/* rtl/setpoint_ramp_generator_macros.svh */
// Assertion macros for the setpoint ramp generator.
// Uses the clk and rst_n names of the module that includes this file.
`ifndef SETPOINT_RAMP_GENERATOR_MACROS_SVH
`define SETPOINT_RAMP_GENERATOR_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define SRG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("setpoint ramp generator check failed");

// Consequent must hold in the cycle after the antecedent
`define SRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("setpoint ramp generator check failed");

`else

`define SRG_ASSERT_SAME(label, ante, cons)
`define SRG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/srg_pkg.sv */
// Shared constants for the setpoint ramp generator.
// No dependencies.
package srg_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int PERIOD_WIDTH    = 16;   // frame period is unsigned Q0.16
    localparam int CFG_IDX_WIDTH   = 3;

    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MODE          = 3'd0;
    localparam cfg_idx_t CFG_INCREASE_STEP = 3'd1;
    localparam cfg_idx_t CFG_DECREASE_STEP = 3'd2;
    localparam cfg_idx_t CFG_FRAME_PERIOD  = 3'd3;
    localparam cfg_idx_t CFG_MAX_OUTPUT    = 3'd4;
    localparam cfg_idx_t CFG_MIN_OUTPUT    = 3'd5;

    localparam logic MODE_SLEW      = 1'b0;
    localparam logic MODE_INTEGRATE = 1'b1;

endpackage

/* rtl/setpoint_ramp_generator.sv */
// Setpoint ramp generator: slew-rate limiter with measured snap, or clamped integrator.
// Inputs are registered in target_reg/measured_reg, then the result in current_output_reg.
// Throughput: 1 item per cycle unless stalled; current_output and plan update per item.
// Reset: asynchronous, active low; clears configuration, state and both valid flags.
// Depends on srg_pkg and setpoint_ramp_generator_macros.svh.
`include "setpoint_ramp_generator_macros.svh"

module setpoint_ramp_generator
    import srg_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  cfg_idx_t                      cfg_index,
    input  logic [VALUE_WIDTH-1:0]        cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] target,
    input  logic signed [VALUE_WIDTH-1:0] measured,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] output_res
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = PERIOD_WIDTH;

    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+PW:0] ROUND_HALF = {{(W+1){1'b0}}, 1'b1, {(PW-1){1'b0}}};

    // Configuration
    logic                  mode_reg;
    logic [W-2:0]          increase_step_reg;
    logic [W-2:0]          decrease_step_reg;
    logic [PW-1:0]         frame_period_reg;
    logic signed [W-1:0]   max_output_reg;
    logic signed [W-1:0]   min_output_reg;

    // State
    logic signed [W-1:0]   current_output_reg;
    logic signed [W-1:0]   planned_value_reg;
    logic signed [W-1:0]   output_next;
    logic signed [W-1:0]   planned_next;

    // Input stage and handshake
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic signed [W-1:0]   target_reg;
    logic signed [W-1:0]   measured_reg;
    logic                  advance;
    logic                  in_take;
    logic                  fire;

    // Slew path
    logic                  snap;
    logic signed [W-1:0]   o_snap;
    logic signed [W:0]     diff_s;
    logic [W:0]            diff_mag;
    logic                  up;
    logic                  use_inc;
    logic [W-2:0]          step_sel;
    logic signed [W:0]     step_ext;
    logic signed [W:0]     step_sum;
    logic signed [W-1:0]   step_sat;
    logic signed [W-1:0]   slew_out;

    // Integrate path
    logic signed [W+PW:0]  prod;
    logic signed [W+PW:0]  prod_round;
    logic signed [W:0]     delta;
    logic signed [W+1:0]   int_sum;
    logic signed [W-1:0]   int_sat;
    logic signed [W-1:0]   int_out;

    assign cfg_ready  = 1'b1;
    assign advance    = !out_valid_reg || !out_stall;
    assign in_stall   = in_valid_reg && !advance;
    assign in_take    = in_valid && !in_stall;
    assign fire       = in_valid_reg && advance;
    assign out_valid  = out_valid_reg;
    assign output_res = current_output_reg;

    // Slew: snap to measured when it lies between plan and target, then step from there
    always_comb
    begin
        snap = ((target_reg >= measured_reg) && (measured_reg >= planned_value_reg)) ||
               ((target_reg <= measured_reg) && (measured_reg <= planned_value_reg));
        o_snap = snap ? measured_reg : current_output_reg;

        diff_s   = {planned_value_reg[W-1], planned_value_reg} - {target_reg[W-1], target_reg};
        diff_mag = diff_s[W] ? (W+1)'(-diff_s) : diff_s;

        up = target_reg > planned_value_reg;
        // increase step when moving away from zero, or from a zero plan
        use_inc = (planned_value_reg == '0) ||
                  (!planned_value_reg[W-1] && up) ||
                  (planned_value_reg[W-1] && !up);
        step_sel = use_inc ? increase_step_reg : decrease_step_reg;
        step_ext = $signed({2'b00, step_sel});

        step_sum = up ? ({o_snap[W-1], o_snap} + step_ext) : ({o_snap[W-1], o_snap} - step_ext);
        if (step_sum[W] != step_sum[W-1])
            step_sat = step_sum[W] ? VAL_MIN : VAL_MAX;
        else
            step_sat = step_sum[W-1:0];

        if (target_reg == planned_value_reg)
            slew_out = o_snap;
        else if (diff_mag > {2'b00, step_sel})
            slew_out = step_sat;
        else
            slew_out = target_reg;
    end

    // Integrate: round(target * period), saturating add, then clamp (upper test first)
    always_comb
    begin
        prod       = target_reg * $signed({1'b0, frame_period_reg});
        prod_round = prod + ROUND_HALF;
        delta      = prod_round[W+PW:PW];
        int_sum    = {{2{current_output_reg[W-1]}}, current_output_reg} + {delta[W], delta};
        if ((int_sum[W+1] != int_sum[W]) || (int_sum[W] != int_sum[W-1]))
            int_sat = int_sum[W+1] ? VAL_MIN : VAL_MAX;
        else
            int_sat = int_sum[W-1:0];

        if (int_sat > max_output_reg)
            int_out = max_output_reg;
        else if (int_sat < min_output_reg)
            int_out = min_output_reg;
        else
            int_out = int_sat;
    end

    always_comb
    begin
        if (mode_reg == MODE_SLEW)
        begin
            output_next  = slew_out;
            planned_next = slew_out;
        end
        else
        begin
            output_next  = int_out;
            planned_next = planned_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_SLEW;
            increase_step_reg  <= '0;
            decrease_step_reg  <= '0;
            frame_period_reg   <= '0;
            max_output_reg     <= '0;
            min_output_reg     <= '0;
            current_output_reg <= '0;
            planned_value_reg  <= '0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:          mode_reg          <= cfg_data[0];
                    CFG_INCREASE_STEP: increase_step_reg <= cfg_data[W-2:0];
                    CFG_DECREASE_STEP: decrease_step_reg <= cfg_data[W-2:0];
                    CFG_FRAME_PERIOD:  frame_period_reg  <= cfg_data[PW-1:0];
                    CFG_MAX_OUTPUT:    max_output_reg    <= $signed(cfg_data);
                    CFG_MIN_OUTPUT:    min_output_reg    <= $signed(cfg_data);
                    default: ;
                endcase
            end

            if (in_take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                current_output_reg <= output_next;
                planned_value_reg  <= planned_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            target_reg   <= target;
            measured_reg <= measured;
        end
    end

    // A held input item is not overwritten while the result register is blocked
    `SRG_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance, in_valid_reg && $stable(target_reg) && $stable(measured_reg))
    // Slew mode: the result becomes the new plan
    `SRG_ASSERT_NEXT(a_slew_plan, fire && (mode_reg == MODE_SLEW), planned_value_reg == current_output_reg)
    // Integrate mode leaves the plan alone
    `SRG_ASSERT_NEXT(a_int_plan, fire && (mode_reg == MODE_INTEGRATE), $stable(planned_value_reg))
    // Integrate mode with a sane clamp range stays inside it
    `SRG_ASSERT_NEXT(a_int_clamp, fire && (mode_reg == MODE_INTEGRATE) && (min_output_reg <= max_output_reg), (current_output_reg <= $past(max_output_reg)) && (current_output_reg >= $past(min_output_reg)))
    // A result appears only after an item was processed
    `SRG_ASSERT_SAME(a_out_source, $rose(out_valid_reg), $past(fire))

endmodule
